/* design/cde_pkg.sv */
// Shared types, field widths and operation codes for the cursor deque engine.
`default_nettype none

package cde_pkg;

   // Default number of element cells in the row
   localparam int CAPACITY_DEF = 64;

   // Field widths of the request and response words
   localparam int KIND_W   = 4;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;
   localparam int POS_W    = 7;
   localparam int RSP_W    = STATUS_W + COUNT_W + POS_W + 3 * VALUE_W;

   // Operation kinds carried on req_tuser
   localparam logic [KIND_W-1:0] KIND_QUERY      = 4'd0;
   localparam logic [KIND_W-1:0] KIND_PREPEND    = 4'd1;
   localparam logic [KIND_W-1:0] KIND_APPEND     = 4'd2;
   localparam logic [KIND_W-1:0] KIND_INS_BEFORE = 4'd3;
   localparam logic [KIND_W-1:0] KIND_INS_AFTER  = 4'd4;
   localparam logic [KIND_W-1:0] KIND_DEL_FRONT  = 4'd5;
   localparam logic [KIND_W-1:0] KIND_DEL_BACK   = 4'd6;
   localparam logic [KIND_W-1:0] KIND_DEL_CURSOR = 4'd7;
   localparam logic [KIND_W-1:0] KIND_TO_FRONT   = 4'd8;
   localparam logic [KIND_W-1:0] KIND_TO_BACK    = 4'd9;
   localparam logic [KIND_W-1:0] KIND_STEP_BACK  = 4'd10;
   localparam logic [KIND_W-1:0] KIND_STEP_FWD   = 4'd11;
   localparam logic [KIND_W-1:0] KIND_CLEAR      = 4'd12;

   // Response status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOCUR = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

   // Cursor position reported when the cursor is undefined (minus one)
   localparam logic [POS_W-1:0] CURSOR_NONE = 7'h7F;

   // Shift command broadcast to every cell of the row
   typedef struct packed {
      logic ins;   // open a slot at the position, cells above take their left neighbour
      logic del;   // close the slot at the position, cells above take their right neighbour
   } cell_op_type;

endpackage

`default_nettype wire

/* design/cde_cell.sv */
// One element cell of the row: holds a value, shifts with its neighbours, drives read taps.
`default_nettype none

module cde_cell #(
   parameter int IDX_W = $clog2(cde_pkg::CAPACITY_DEF),
   parameter int INDEX = 0
) (
   input  wire                                 clock,
   input  cde_pkg::cell_op_type                op,
   input  wire        [IDX_W-1:0]              op_pos,
   input  wire signed [cde_pkg::VALUE_W-1:0]   op_value,
   input  wire signed [cde_pkg::VALUE_W-1:0]   left_value,
   input  wire signed [cde_pkg::VALUE_W-1:0]   right_value,
   input  wire        [IDX_W-1:0]              back_idx,
   input  wire        [IDX_W-1:0]              cur_idx,
   output logic signed [cde_pkg::VALUE_W-1:0]  value_out,
   output logic signed [cde_pkg::VALUE_W-1:0]  back_tap,
   output logic signed [cde_pkg::VALUE_W-1:0]  cur_tap
);
   import cde_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   // Pick the next value from the shift command
   always_comb begin
      value_in = value_ff;
      if (op.ins) begin
         if (MY_IDX > op_pos) begin
            value_in = left_value;
         end else if (MY_IDX == op_pos) begin
            value_in = op_value;
         end
      end else if (op.del) begin
         if (MY_IDX >= op_pos) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // Drive the read taps only when this cell is addressed
   assign value_out = value_ff;
   assign back_tap  = (MY_IDX == back_idx) ? value_ff : '0;
   assign cur_tap   = (MY_IDX == cur_idx)  ? value_ff : '0;

endmodule

`default_nettype wire

/* design/cde_ctrl.sv */
// Sequencer: takes request words, keeps length and cursor, drives the cell row, forms responses.
`default_nettype none

module cde_ctrl #(
   parameter int CAPACITY = cde_pkg::CAPACITY_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire        [cde_pkg::VALUE_W-1:0]    req_tdata,
   input  wire        [cde_pkg::KIND_W-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic       [cde_pkg::RSP_W-1:0]      rsp_tdata,
   output cde_pkg::cell_op_type                 op,
   output logic       [$clog2(CAPACITY)-1:0]    op_pos,
   output logic signed [cde_pkg::VALUE_W-1:0]   op_value,
   output logic       [$clog2(CAPACITY)-1:0]    back_idx,
   output logic       [$clog2(CAPACITY)-1:0]    cur_idx,
   input  wire signed [cde_pkg::VALUE_W-1:0]    head_value,
   input  wire signed [cde_pkg::VALUE_W-1:0]    back_value,
   input  wire signed [cde_pkg::VALUE_W-1:0]    cur_value
);
   import cde_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SEL  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [KIND_W-1:0]         kind_ff, kind_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]          len_ff, len_in;
   logic                      def_ff, def_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [STATUS_W-1:0]       stat_ff, stat_in;
   logic signed [VALUE_W-1:0] front_sel_ff, back_sel_ff, cur_sel_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]          rsp_data_ff;
   logic                      slot_free;

   logic             is_empty;
   logic             is_full;
   logic [CNT_W-1:0] len_m1;
   logic [CNT_W-1:0] len_p1;
   logic [IDX_W-1:0] idx_p1;
   logic [IDX_W-1:0] idx_m1;
   logic             cur_at_front;
   logic             cur_at_back;
   logic [POS_W-1:0] pos_field;

   // Conditions on the list as it stands before the operation
   assign is_empty     = (len_ff == '0);
   assign is_full      = (len_ff == CNT_W'(CAPACITY));
   assign len_m1       = len_ff - 1'b1;
   assign len_p1       = len_ff + 1'b1;
   assign idx_p1       = IDX_W'(idx_ff + 1'b1);
   assign idx_m1       = IDX_W'(idx_ff - 1'b1);
   assign cur_at_front = (idx_ff == '0);
   assign cur_at_back  = (CNT_W'(idx_ff) == len_m1);
   assign slot_free    = !rsp_valid_ff || rsp_tready;

   // Sequence one word through execute, tap select and result load
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      value_in = value_ff;
      len_in   = len_ff;
      def_in   = def_ff;
      idx_in   = idx_ff;
      stat_in  = stat_ff;
      op       = '0;
      op_pos   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               value_in = req_tdata;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            stat_in  = STAT_OK;
            state_in = S_SEL;
            unique case (kind_ff)
               KIND_PREPEND: begin
                  if (is_full) begin
                     stat_in = STAT_FULL;
                  end else begin
                     op.ins = 1'b1;
                     len_in = len_p1;
                     if (def_ff) begin
                        idx_in = idx_p1;
                     end
                  end
               end
               KIND_APPEND: begin
                  if (is_full) begin
                     stat_in = STAT_FULL;
                  end else begin
                     op.ins = 1'b1;
                     op_pos = IDX_W'(len_ff);
                     len_in = len_p1;
                  end
               end
               KIND_INS_BEFORE, KIND_INS_AFTER: begin
                  priority if (is_empty) begin
                     stat_in = STAT_EMPTY;
                  end else if (!def_ff) begin
                     stat_in = STAT_NOCUR;
                  end else if (is_full) begin
                     stat_in = STAT_FULL;
                  end else begin
                     op.ins = 1'b1;
                     len_in = len_p1;
                     if (kind_ff == KIND_INS_BEFORE) begin
                        op_pos = idx_ff;
                        idx_in = idx_p1;
                     end else begin
                        op_pos = idx_p1;
                     end
                  end
               end
               KIND_DEL_FRONT: begin
                  if (is_empty) begin
                     stat_in = STAT_EMPTY;
                  end else begin
                     op.del = 1'b1;
                     len_in = len_m1;
                     if (def_ff) begin
                        if (cur_at_front) begin
                           def_in = 1'b0;
                        end else begin
                           idx_in = idx_m1;
                        end
                     end
                  end
               end
               KIND_DEL_BACK: begin
                  // The last element simply falls off the end of the length
                  if (is_empty) begin
                     stat_in = STAT_EMPTY;
                  end else begin
                     len_in = len_m1;
                     if (def_ff && cur_at_back) begin
                        def_in = 1'b0;
                     end
                  end
               end
               KIND_DEL_CURSOR: begin
                  if (!def_ff) begin
                     stat_in = STAT_NOCUR;
                  end else begin
                     op.del = 1'b1;
                     op_pos = idx_ff;
                     len_in = len_m1;
                     def_in = 1'b0;
                  end
               end
               KIND_TO_FRONT: begin
                  if (is_empty) begin
                     stat_in = STAT_EMPTY;
                  end else begin
                     def_in = 1'b1;
                     idx_in = '0;
                  end
               end
               KIND_TO_BACK: begin
                  if (is_empty) begin
                     stat_in = STAT_EMPTY;
                  end else begin
                     def_in = 1'b1;
                     idx_in = IDX_W'(len_m1);
                  end
               end
               KIND_STEP_BACK: begin
                  if (!def_ff) begin
                     stat_in = STAT_NOCUR;
                  end else if (cur_at_front) begin
                     def_in = 1'b0;
                  end else begin
                     idx_in = idx_m1;
                  end
               end
               KIND_STEP_FWD: begin
                  if (!def_ff) begin
                     stat_in = STAT_NOCUR;
                  end else if (cur_at_back) begin
                     def_in = 1'b0;
                  end else begin
                     idx_in = idx_p1;
                  end
               end
               KIND_CLEAR: begin
                  len_in = '0;
                  def_in = 1'b0;
               end
               default: begin
                  // query and unused kinds leave the list alone
               end
            endcase
         end
         S_SEL: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // Hold the response until taken, refill from the finishing word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == S_FIN && slot_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign pos_field = def_ff ? POS_W'(idx_ff) : CURSOR_NONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         def_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         def_ff       <= def_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      stat_ff  <= stat_in;
      // Capture the tapped values once the row has settled
      if (state_ff == S_SEL) begin
         front_sel_ff <= is_empty ? '0 : head_value;
         back_sel_ff  <= is_empty ? '0 : back_value;
         cur_sel_ff   <= def_ff ? cur_value : '0;
      end
      if (state_ff == S_FIN && slot_free) begin
         rsp_data_ff <= {cur_sel_ff, back_sel_ff, front_sel_ff, pos_field,
                         COUNT_W'(len_ff), stat_ff};
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign op_value   = value_ff;
   assign back_idx   = IDX_W'(len_m1);
   assign cur_idx    = idx_ff;

endmodule

`default_nettype wire

/* design/cursor_deque_engine.sv */
// Top level: a row of element cells under one sequencer, forming a list with a cursor.
`default_nettype none

// The list is held in order in a row of CAPACITY cells, element i in cell i. An insert
// or any delete but at the back is one shift step in which every cell above the position
// takes its left or right neighbour, so any operation costs the same. Each request word
// passes through accept, a shift step through the row, selection of the back and cursor
// cells, and load of the response register; the next word is taken in the cycle after the
// load, and a response stalled by rsp_tready holds the engine in its load cycle. The back
// and cursor values are read by address through an AND-OR select across the whole row.
// Nothing needs clearing after reset: the length alone marks which cells hold elements.
module cursor_deque_engine #(
   parameter int CAPACITY = cde_pkg::CAPACITY_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire [cde_pkg::VALUE_W-1:0]       req_tdata,   // value[31:0]
   input  wire [cde_pkg::KIND_W-1:0]        req_tuser,   // kind[3:0]
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [cde_pkg::RSP_W-1:0]        rsp_tdata    // status[1:0], item_count[8:2],
                                                         // cursor_position[15:9],
                                                         // front_value[47:16],
                                                         // back_value[79:48],
                                                         // cursor_value[111:80]
);
   import cde_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);

   cell_op_type               op;
   logic [IDX_W-1:0]          op_pos;
   logic signed [VALUE_W-1:0] op_value;
   logic [IDX_W-1:0]          back_idx;
   logic [IDX_W-1:0]          cur_idx;
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic signed [VALUE_W-1:0] left_value [CAPACITY];
   logic signed [VALUE_W-1:0] right_value [CAPACITY];
   logic signed [VALUE_W-1:0] back_tap [CAPACITY];
   logic signed [VALUE_W-1:0] cur_tap [CAPACITY];
   logic signed [VALUE_W-1:0] back_bus;
   logic signed [VALUE_W-1:0] cur_bus;

   cde_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .op         (op),
      .op_pos     (op_pos),
      .op_value   (op_value),
      .back_idx   (back_idx),
      .cur_idx    (cur_idx),
      .head_value (cell_value[0]),
      .back_value (back_bus),
      .cur_value  (cur_bus)
   );

   // Build the row, each cell wired to its neighbours
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign left_value[g] = op_value;
      end else begin : g_left
         assign left_value[g] = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_value[g] = cell_value[g];
      end else begin : g_right
         assign right_value[g] = cell_value[g+1];
      end

      cde_cell #(
         .IDX_W (IDX_W),
         .INDEX (g)
      ) u_cell (
         .clock       (clock),
         .op          (op),
         .op_pos      (op_pos),
         .op_value    (op_value),
         .left_value  (left_value[g]),
         .right_value (right_value[g]),
         .back_idx    (back_idx),
         .cur_idx     (cur_idx),
         .value_out   (cell_value[g]),
         .back_tap    (back_tap[g]),
         .cur_tap     (cur_tap[g])
      );
   end

   // Merge the taps: at most one cell drives each bus
   always_comb begin
      back_bus = '0;
      cur_bus  = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         back_bus = back_bus | back_tap[i];
         cur_bus  = cur_bus | cur_tap[i];
      end
   end

   // An accepted word keeps the engine busy for the following cycles
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready ##1 !req_tready)
      else $error("engine took a word while still working on the previous one");

   // A new response is only raised when no word could be taken just before it
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response raised outside the load cycle");

   // An empty-list refusal reports an empty list
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] == STAT_EMPTY)) |-> (rsp_tdata[8:2] == '0))
      else $error("empty status with a nonzero element count");

endmodule

`default_nettype wire

/* tb/sv/cursor_deque_engine_tb.sv */
// Self-checking testbench for the cursor deque engine: ordered-list predictor and response checker.
`timescale 1ns / 100ps

module cursor_deque_engine_tb;
   import cde_pkg::*;

   localparam int TIMEOUT_NS  = 5_000_000;
   localparam int DRAIN_SLACK = 24;

   // Kinds with no operation of their own; the block treats them as a query
   localparam logic [KIND_W-1:0] KIND_SPARE_LO  = 4'd13;
   localparam logic [KIND_W-1:0] KIND_SPARE_MID = 4'd14;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI  = 4'd15;

   typedef enum {READY_ALWAYS, READY_MOSTLY, READY_PATTERN, READY_COIN} ready_mode_type;

   // One response word as the list should report it
   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic [POS_W-1:0]    pos;
      logic [VALUE_W-1:0]  front;
      logic [VALUE_W-1:0]  back;
      logic [VALUE_W-1:0]  cur;
   } list_snapshot_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [VALUE_W-1:0]  req_tdata  = '0;   // value[31:0]
   logic [KIND_W-1:0]   req_tuser  = '0;   // kind[3:0]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;         // status[1:0], item_count[8:2], cursor_position[15:9],
                                           // front_value[47:16], back_value[79:48],
                                           // cursor_value[111:80]

   // Predicted list contents in order, and the cursor index (-1 when undefined)
   logic [VALUE_W-1:0]  list_elems[$];
   int                  cursor_idx = -1;
   list_snapshot_type   pending_snapshots[$];
   list_snapshot_type   want;
   int                  error_count = 0;

   // Sender burst control and receiver hold-off request
   int                  burst_left = 0;
   bit                  sender_steady = 1'b0;
   int                  fill_goal = 8;
   int                  long_hold_cycles = 0;
   int                  hold_left = 0;
   int                  pattern_left = 0;
   int                  phase_count = 0;
   ready_mode_type      stall_mode = READY_ALWAYS;

   cursor_deque_engine DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Advance the predicted list by one operation and queue the snapshot it should report
   task automatic apply_list_op(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
      list_snapshot_type snap;
      int len;
      len = list_elems.size();
      snap.status = STAT_OK;
      case (kind)
         KIND_PREPEND, KIND_APPEND: begin
            if (len >= CAPACITY_DEF) begin
               snap.status = STAT_FULL;
            end else if (kind == KIND_PREPEND) begin
               list_elems.push_front(value);
               if (cursor_idx >= 0) cursor_idx++;
            end else begin
               list_elems.push_back(value);
            end
         end
         KIND_INS_BEFORE, KIND_INS_AFTER: begin
            if (len == 0) snap.status = STAT_EMPTY;
            else if (cursor_idx < 0) snap.status = STAT_NOCUR;
            else if (len >= CAPACITY_DEF) snap.status = STAT_FULL;
            else if (kind == KIND_INS_BEFORE) begin
               list_elems.insert(cursor_idx, value);
               cursor_idx++;
            end else if (cursor_idx == len - 1) begin
               list_elems.push_back(value);
            end else begin
               list_elems.insert(cursor_idx + 1, value);
            end
         end
         KIND_DEL_FRONT: begin
            if (len == 0) snap.status = STAT_EMPTY;
            else begin
               void'(list_elems.pop_front());
               if (cursor_idx == 0) cursor_idx = -1;
               else if (cursor_idx > 0) cursor_idx--;
            end
         end
         KIND_DEL_BACK: begin
            if (len == 0) snap.status = STAT_EMPTY;
            else begin
               if (cursor_idx == len - 1) cursor_idx = -1;
               void'(list_elems.pop_back());
            end
         end
         KIND_DEL_CURSOR: begin
            if (cursor_idx < 0) snap.status = STAT_NOCUR;
            else begin
               list_elems.delete(cursor_idx);
               cursor_idx = -1;
            end
         end
         KIND_TO_FRONT, KIND_TO_BACK: begin
            if (len == 0) snap.status = STAT_EMPTY;
            else cursor_idx = (kind == KIND_TO_FRONT) ? 0 : len - 1;
         end
         KIND_STEP_BACK: begin
            if (cursor_idx < 0) snap.status = STAT_NOCUR;
            else cursor_idx = cursor_idx - 1;
         end
         KIND_STEP_FWD: begin
            if (cursor_idx < 0) snap.status = STAT_NOCUR;
            else if (cursor_idx == len - 1) cursor_idx = -1;
            else cursor_idx++;
         end
         KIND_CLEAR: begin
            list_elems.delete();
            cursor_idx = -1;
         end
         default: ;
      endcase
      len = list_elems.size();
      snap.count = len[COUNT_W-1:0];
      snap.pos   = (cursor_idx < 0) ? CURSOR_NONE : cursor_idx[POS_W-1:0];
      snap.front = (len > 0) ? list_elems[0] : '0;
      snap.back  = (len > 0) ? list_elems[len-1] : '0;
      snap.cur   = (cursor_idx >= 0) ? list_elems[cursor_idx] : '0;
      pending_snapshots.push_back(snap);
   endtask

   // Offer one request word, with a random gap between bursts, and hold it until taken
   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
      if (!sender_steady) begin
         if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) begin
               @(negedge clock);
               req_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_list_op(kind, value);
   endtask

   // Drop valid and hold until every outstanding response has arrived
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_snapshots.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Weight the operations so the list wanders towards the current fill goal
   function automatic logic [KIND_W-1:0] pick_kind();
      logic [KIND_W-1:0] grow_kinds[4];
      logic [KIND_W-1:0] shrink_kinds[3];
      logic [KIND_W-1:0] move_kinds[6];
      logic [KIND_W-1:0] spare_kinds[3];
      int r;
      int grow;
      grow_kinds   = '{KIND_PREPEND, KIND_APPEND, KIND_INS_BEFORE, KIND_INS_AFTER};
      shrink_kinds = '{KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_CURSOR};
      move_kinds   = '{KIND_TO_FRONT, KIND_TO_BACK, KIND_STEP_BACK, KIND_STEP_FWD,
                       KIND_STEP_BACK, KIND_STEP_FWD};
      spare_kinds  = '{KIND_SPARE_LO, KIND_SPARE_MID, KIND_SPARE_HI};
      r = $urandom_range(0, 99);
      grow = (list_elems.size() < fill_goal) ? 50 : 15;
      if (r < 1) return KIND_CLEAR;
      if (r < 3) return spare_kinds[$urandom_range(0, 2)];
      if (r < 6) return KIND_QUERY;
      if (r < 6 + grow) return grow_kinds[$urandom_range(0, 3)];
      if (r < 6 + grow + 20) return shrink_kinds[$urandom_range(0, 2)];
      return move_kinds[$urandom_range(0, 5)];
   endfunction

   // Empty list, every operation, and the cursor edge cases
   task automatic test_directed();
      send_word(KIND_DEL_FRONT, '0);
      send_word(KIND_DEL_BACK, '0);
      send_word(KIND_DEL_CURSOR, '0);
      send_word(KIND_TO_FRONT, '0);
      send_word(KIND_STEP_BACK, '0);
      send_word(KIND_INS_BEFORE, 32'h1234_5678);
      send_word(KIND_PREPEND, 32'h7FFF_FFFF);
      send_word(KIND_APPEND, 32'h8000_0000);
      send_word(KIND_INS_AFTER, 32'h0000_0001);
      send_word(KIND_TO_FRONT, '0);
      send_word(KIND_PREPEND, 32'hFFFF_FFFF);
      send_word(KIND_INS_BEFORE, 32'h0000_0000);
      send_word(KIND_INS_AFTER, 32'h0000_0005);
      send_word(KIND_STEP_BACK, '0);
      send_word(KIND_STEP_BACK, '0);
      send_word(KIND_STEP_BACK, '0);
      send_word(KIND_TO_BACK, '0);
      send_word(KIND_STEP_FWD, '0);
      send_word(KIND_TO_BACK, '0);
      send_word(KIND_DEL_BACK, '0);
      send_word(KIND_TO_FRONT, '0);
      send_word(KIND_STEP_FWD, '0);
      send_word(KIND_DEL_FRONT, '0);
      send_word(KIND_STEP_FWD, '0);
      send_word(KIND_DEL_CURSOR, '0);
      send_word(KIND_SPARE_LO, 32'hFFFF_FFFF);
      send_word(KIND_SPARE_HI, '0);
      send_word(KIND_CLEAR, '0);
      send_word(KIND_QUERY, '0);
   endtask

   // Fill the pool, knock on the full limit from every insert, then empty it again
   task automatic test_full_pool();
      send_word(KIND_CLEAR, '0);
      while (list_elems.size() < CAPACITY_DEF)
         send_word(($urandom_range(0, 1) != 0) ? KIND_APPEND : KIND_PREPEND, pick_value());
      send_word(KIND_PREPEND, pick_value());
      send_word(KIND_APPEND, pick_value());
      send_word(KIND_INS_BEFORE, pick_value());
      send_word(KIND_TO_FRONT, '0);
      send_word(KIND_INS_BEFORE, pick_value());
      send_word(KIND_INS_AFTER, pick_value());
      send_word(KIND_TO_BACK, '0);
      send_word(KIND_STEP_BACK, '0);
      send_word(KIND_DEL_CURSOR, '0);
      send_word(KIND_TO_BACK, '0);
      send_word(KIND_INS_AFTER, pick_value());
      send_word(KIND_INS_BEFORE, pick_value());
      repeat (8) send_word(KIND_STEP_BACK, '0);
      while (list_elems.size() > 0)
         send_word(($urandom_range(0, 1) != 0) ? KIND_DEL_FRONT : KIND_DEL_BACK, '0);
      send_word(KIND_DEL_BACK, '0);
   endtask

   // Stall the receiver for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      sender_steady = 1'b1;
      long_hold_cycles = 400;
      repeat (40) send_word(pick_kind(), pick_value());
      sender_steady = 1'b0;
   endtask

   // Long random run in segments, each with its own fill goal and sender behaviour
   task automatic test_random_ops();
      for (int seg = 0; seg < 13; seg++) begin
         fill_goal = ($urandom_range(0, 3) == 0) ? CAPACITY_DEF + 1 : $urandom_range(1, 40);
         sender_steady = (seg % 4 == 3);
         repeat (100) send_word(pick_kind(), pick_value());
         if (seg % 5 == 2) wait_drained();
      end
      sender_steady = 1'b0;
   endtask

   // Receiver: switch among ready patterns, or hold off when a long stall is asked for
   always @(negedge clock) begin
      if (long_hold_cycles > 0) begin
         hold_left = long_hold_cycles;
         long_hold_cycles = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            stall_mode = ready_mode_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(50, 300);
         end
         pattern_left--;
         phase_count++;
         case (stall_mode)
            READY_ALWAYS:  rsp_tready <= 1'b1;
            READY_MOSTLY:  rsp_tready <= ($urandom_range(0, 3) != 0);
            READY_PATTERN: rsp_tready <= ((phase_count % 7) < 4);
            default:       rsp_tready <= ($urandom_range(0, 1) != 0);
         endcase
      end
   end

   function automatic void check_field(input string name, input logic [31:0] exp_val,
                                       input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
         error_count++;
      end
   endfunction

   // Compare each accepted response word with the oldest predicted snapshot
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_snapshots.size() == 0) begin
            $display("%0t: unexpected response word, expected none, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_snapshots.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_tdata[1:0]));
            check_field("item_count", 32'(want.count), 32'(rsp_tdata[8:2]));
            check_field("cursor_position", 32'(want.pos), 32'(rsp_tdata[15:9]));
            check_field("front_value", want.front, rsp_tdata[47:16]);
            check_field("back_value", want.back, rsp_tdata[79:48]);
            check_field("cursor_value", want.cur, rsp_tdata[111:80]);
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("[cursor_deque_engine] ERROR");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      wait_drained();
      test_full_pool();
      wait_drained();
      test_backpressure();
      wait_drained();
      test_random_ops();
      wait_drained();
      if (error_count == 0)
         $display("[cursor_deque_engine] OK");
      else
         $display("[cursor_deque_engine] ERROR");
      $finish;
   end

endmodule
